/* rtl/bdlp_pkg.sv */
// ----------------------------------------------------------------------------
// bdlp_pkg: shared types and constants for the button debouncer
// Beat payloads, event codes, register indexes and the per-button state.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  localparam int NUM_BUTTONS = 16;
  localparam int IDX_W       = 4;
  localparam int CFG_W       = 16;
  localparam int CNT_W       = 16;
  localparam int HOLD_W      = 17;

  typedef enum logic [2:0] {
    EV_NONE          = 3'd0,
    EV_PRESS         = 3'd1,
    EV_LONG_START    = 3'd2,
    EV_LONG_RELEASE  = 3'd3,
    EV_SHORT_RELEASE = 3'd4
  } ev_code_t;

  typedef enum logic [1:0] {
    CFG_SCAN_PERIOD = 2'd0,
    CFG_STABLE      = 2'd1,
    CFG_LONG_PRESS  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [IDX_W-1:0] button_index;
    logic             pressed;
  } in_item_t;

  typedef struct packed {
    ev_code_t         event_code;
    logic [IDX_W-1:0] event_button;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] scan_period_ms;
    logic [CFG_W-1:0] stable_ms;
    logic [CFG_W-1:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic              is_pressed;
    logic              is_bouncing;
    logic              long_reported;
    logic [CNT_W-1:0]  debounce_left;
    logic [HOLD_W-1:0] hold_elapsed;
  } btn_state_t;

endpackage

/* rtl/bdlp_step.sv */
// ----------------------------------------------------------------------------
// bdlp_step: next-state and event logic for one button
// Applies one sampled level to the state of the addressed button.
// ----------------------------------------------------------------------------
module bdlp_step (
  input  bdlp_pkg::cfg_t       cfg,
  input  bdlp_pkg::btn_state_t cur,
  input  logic                 level,
  output bdlp_pkg::btn_state_t nxt,
  output bdlp_pkg::ev_code_t   ev
);
  import bdlp_pkg::*;

  logic [HOLD_W:0]   hold_sum;
  logic [HOLD_W-1:0] hold_sat;

  assign hold_sum = {1'b0, cur.hold_elapsed} + {{(HOLD_W+1-CFG_W){1'b0}}, cfg.scan_period_ms};
  // The hold timer saturates at its all-ones value.
  assign hold_sat = hold_sum[HOLD_W] ? {HOLD_W{1'b1}} : hold_sum[HOLD_W-1:0];

  always_comb begin
    nxt = cur;
    ev  = EV_NONE;
    if (level) begin
      if (!cur.is_pressed) begin
        nxt.is_pressed    = 1'b1;
        nxt.is_bouncing   = 1'b1;
        nxt.debounce_left = cfg.stable_ms;
      end else if (cur.is_bouncing) begin
        if (cur.debounce_left > cfg.scan_period_ms) begin
          nxt.debounce_left = cur.debounce_left - cfg.scan_period_ms;
        end else begin
          nxt.is_bouncing = 1'b0;
          ev              = EV_PRESS;
        end
      end else if (cfg.long_press_ms != '0 && !cur.long_reported) begin
        nxt.hold_elapsed = hold_sat;
        if (hold_sat >= {{(HOLD_W-CFG_W){1'b0}}, cfg.long_press_ms}) begin
          nxt.long_reported = 1'b1;
          ev                = EV_LONG_START;
        end
      end
    end else if (cur.is_pressed) begin
      nxt.is_pressed   = 1'b0;
      nxt.hold_elapsed = '0;
      if (cur.is_bouncing) begin
        nxt.is_bouncing = 1'b0;
      end else if (cur.long_reported) begin
        nxt.long_reported = 1'b0;
        ev                = EV_LONG_RELEASE;
      end else begin
        ev = EV_SHORT_RELEASE;
      end
    end
  end

endmodule

/* rtl/button_debounce_long_press.sv */
// A beat accepted into the input stage moves on to the output register when
// that stage advances. Throughput: one sample per cycle while out_ready does
// not stall the output; the per-button state is read and written in the same
// cycle, so back-to-back samples of one button see fresh state.
// Reset clears all button state, both pipeline stages and loads the register
// defaults (scan period 10, stable time 50, long press 1000).
// ----------------------------------------------------------------------------
// button_debounce_long_press: multi-button debouncer with long-press events
// Each input beat is one scan sample; each output beat is the resulting event.
// ----------------------------------------------------------------------------
module button_debounce_long_press (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bdlp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bdlp_pkg::out_item_t  out_data,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [bdlp_pkg::CFG_W-1:0] cfg_wdata
);
  import bdlp_pkg::*;

  cfg_t       cfg_r;
  in_item_t   s1_data_r;
  logic       s1_valid_r;
  logic       s1_adv;
  logic       in_range;
  out_item_t  out_data_r;
  logic       out_valid_r;

  logic [NUM_BUTTONS-1:0] pressed_r;
  logic [NUM_BUTTONS-1:0] bouncing_r;
  logic [NUM_BUTTONS-1:0] long_rep_r;
  logic [CNT_W-1:0]       debounce_r [NUM_BUTTONS];
  logic [HOLD_W-1:0]      hold_r     [NUM_BUTTONS];

  btn_state_t cur_state;
  btn_state_t nxt_state;
  ev_code_t   step_ev;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_range = int'(s1_data_r.button_index) < NUM_BUTTONS;

  assign cur_state.is_pressed    = pressed_r[s1_data_r.button_index];
  assign cur_state.is_bouncing   = bouncing_r[s1_data_r.button_index];
  assign cur_state.long_reported = long_rep_r[s1_data_r.button_index];
  assign cur_state.debounce_left = debounce_r[s1_data_r.button_index];
  assign cur_state.hold_elapsed  = hold_r[s1_data_r.button_index];

  bdlp_step u_step (
    .cfg   (cfg_r),
    .cur   (cur_state),
    .level (s1_data_r.pressed),
    .nxt   (nxt_state),
    .ev    (step_ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scan_period_ms <= CFG_W'(10);
      cfg_r.stable_ms      <= CFG_W'(50);
      cfg_r.long_press_ms  <= CFG_W'(1000);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SCAN_PERIOD: cfg_r.scan_period_ms <= cfg_wdata;
        CFG_STABLE:      cfg_r.stable_ms      <= cfg_wdata;
        CFG_LONG_PRESS:  cfg_r.long_press_ms  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r  <= '0;
      bouncing_r <= '0;
      long_rep_r <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        debounce_r[i] <= '0;
        hold_r[i]     <= '0;
      end
    end else if (s1_adv && in_range) begin
      pressed_r[s1_data_r.button_index]  <= nxt_state.is_pressed;
      bouncing_r[s1_data_r.button_index] <= nxt_state.is_bouncing;
      long_rep_r[s1_data_r.button_index] <= nxt_state.long_reported;
      debounce_r[s1_data_r.button_index] <= nxt_state.debounce_left;
      hold_r[s1_data_r.button_index]     <= nxt_state.hold_elapsed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.event_code   <= in_range ? step_ev : EV_NONE;
      out_data_r.event_button <= s1_data_r.button_index;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A button can only be debouncing or past its long press while held down.
  a_bounce_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    (bouncing_r & ~pressed_r) == '0)
    else $error("debounce flag set on a released button");

  a_long_needs_confirm: assert property (@(posedge clk) disable iff (!rst_n)
    (long_rep_r & (~pressed_r | bouncing_r)) == '0)
    else $error("long press flag set on an unconfirmed button");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("sample left the input stage without producing a result");

endmodule

/* dv/bdlp_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_tb_pkg: event tracking for the button debouncer testbench
// Mirrors the per-button debounce and hold state and queues the event that
// each accepted scan sample should produce, then checks the output beats.
// ----------------------------------------------------------------------------
package bdlp_tb_pkg;

  import bdlp_pkg::*;

  localparam int unsigned HOLD_SAT = 131071;

  class button_event_tracker;
    logic [CFG_W-1:0] scan_period;
    logic [CFG_W-1:0] stable_time;
    logic [CFG_W-1:0] long_time;
    bit               held       [NUM_BUTTONS];
    bit               bouncing   [NUM_BUTTONS];
    bit               long_seen  [NUM_BUTTONS];
    int unsigned      debounce_ms[NUM_BUTTONS];
    int unsigned      hold_ms    [NUM_BUTTONS];
    out_item_t        expected_events[$];
    int               mismatches;
    int               samples_taken;
    int               events_by_code[5];

    function new();
      scan_period   = 16'd10;
      stable_time   = 16'd50;
      long_time     = 16'd1000;
      mismatches    = 0;
      samples_taken = 0;
    endfunction

    function void set_register(cfg_index_t idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_SCAN_PERIOD: scan_period = value;
        CFG_STABLE:      stable_time = value;
        CFG_LONG_PRESS:  long_time   = value;
        default: ;
      endcase
    endfunction

    function ev_code_t predict_event(in_item_t s);
      int unsigned b;
      b = 32'(s.button_index);
      if (b >= NUM_BUTTONS) return EV_NONE;
      if (s.pressed) begin
        if (!held[b]) begin
          held[b]        = 1'b1;
          bouncing[b]    = 1'b1;
          debounce_ms[b] = 32'(stable_time);
          return EV_NONE;
        end
        if (bouncing[b]) begin
          if (debounce_ms[b] > 32'(scan_period)) begin
            debounce_ms[b] -= 32'(scan_period);
            return EV_NONE;
          end
          bouncing[b] = 1'b0;
          return EV_PRESS;
        end
        if (long_time == 0 || long_seen[b]) return EV_NONE;
        hold_ms[b] += 32'(scan_period);
        if (hold_ms[b] > HOLD_SAT) hold_ms[b] = HOLD_SAT;
        if (hold_ms[b] < 32'(long_time)) return EV_NONE;
        long_seen[b] = 1'b1;
        return EV_LONG_START;
      end
      if (!held[b]) return EV_NONE;
      // The hold timer is cleared on every release, even one during debounce.
      held[b]    = 1'b0;
      hold_ms[b] = 0;
      if (bouncing[b]) begin
        bouncing[b] = 1'b0;
        return EV_NONE;
      end
      if (long_seen[b]) begin
        long_seen[b] = 1'b0;
        return EV_LONG_RELEASE;
      end
      return EV_SHORT_RELEASE;
    endfunction

    function void note_sample(in_item_t s);
      out_item_t exp_ev;
      exp_ev.event_code   = predict_event(s);
      exp_ev.event_button = s.button_index;
      expected_events.push_back(exp_ev);
      samples_taken++;
    endfunction

    function void check_event(out_item_t got);
      out_item_t exp_ev;
      if (expected_events.size() == 0) begin
        $error("event for button %0d arrived with nothing expected", got.event_button);
        mismatches++;
        return;
      end
      exp_ev = expected_events.pop_front();
      if (got.event_code !== exp_ev.event_code) begin
        $error("event_code: expected %0d, actual %0d", exp_ev.event_code, got.event_code);
        mismatches++;
      end
      if (got.event_button !== exp_ev.event_button) begin
        $error("event_button: expected %0d, actual %0d", exp_ev.event_button,
               got.event_button);
        mismatches++;
      end
      events_by_code[int'(exp_ev.event_code)]++;
    endfunction

    function int pending();
      return expected_events.size();
    endfunction
  endclass

endpackage

/* dv/tb_button_debounce_long_press.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_long_press: self-checking bench for the debouncer
// Drives scan samples under random back-pressure across several register
// settings and compares every event beat with the tracker's prediction.
// ----------------------------------------------------------------------------
module tb_button_debounce_long_press;

  import bdlp_pkg::*;
  import bdlp_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_STALL  = 300;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                cfg_wr_en;
  logic [1:0]          cfg_index;
  logic [CFG_W-1:0]    cfg_wdata;

  button_event_tracker tracker;
  int unsigned         cycle_count = 0;
  bit                  idle_enabled;
  bit                  stall_request;
  int                  presses_left[NUM_BUTTONS];
  int                  focus[3];

  button_debounce_long_press dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.note_sample(in_data);
      if (out_valid && out_ready) tracker.check_event(out_data);
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_request) begin
        stall_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else if (idle_enabled && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic send_sample(logic [IDX_W-1:0] button, logic level);
    in_item_t s;
    s.button_index = button;
    s.pressed      = level;
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    if (idle_enabled && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic hold_then_release(logic [IDX_W-1:0] button, int presses);
    repeat (presses) send_sample(button, 1'b1);
    send_sample(button, 1'b0);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(int scan, int stable, int hold);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SCAN_PERIOD;
    cfg_wdata <= CFG_W'(scan);
    @(posedge clk);
    cfg_index <= CFG_STABLE;
    cfg_wdata <= CFG_W'(stable);
    @(posedge clk);
    cfg_index <= CFG_LONG_PRESS;
    cfg_wdata <= CFG_W'(hold);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_register(CFG_SCAN_PERIOD, CFG_W'(scan));
    tracker.set_register(CFG_STABLE, CFG_W'(stable));
    tracker.set_register(CFG_LONG_PRESS, CFG_W'(hold));
  endtask

  // Mostly well-formed press/hold/release runs on a few buttons, with some
  // random levels mixed in as noise.
  task automatic run_phase(int scan, int stable, int hold, int items, bit with_idle,
                           bit with_stall);
    int   deb_steps;
    int   hold_steps;
    int   b;
    int   n;
    logic level;
    apply_settings(scan, stable, hold);
    idle_enabled = with_idle;
    deb_steps    = stable / scan + 2;
    hold_steps   = (hold == 0) ? 4 : hold / scan + 2;
    foreach (focus[i]) focus[i] = $urandom_range(0, NUM_BUTTONS - 1);
    foreach (presses_left[i]) presses_left[i] = 0;
    for (n = 0; n < items; n++) begin
      if (with_stall && n == items / 3) stall_request = 1'b1;
      if ($urandom_range(0, 9) < 7) b = focus[$urandom_range(0, 2)];
      else b = $urandom_range(0, NUM_BUTTONS - 1);
      if ($urandom_range(0, 9) == 0) begin
        level = 1'($urandom_range(0, 1));
      end else if (presses_left[b] > 0) begin
        level = 1'b1;
        presses_left[b]--;
      end else begin
        level = 1'b0;
        if ($urandom_range(0, 1)) presses_left[b] = $urandom_range(1, deb_steps);
        else presses_left[b] = $urandom_range(1, deb_steps + hold_steps + 2);
      end
      send_sample(IDX_W'(b), level);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int scan;
    int k;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_SCAN_PERIOD;
    cfg_wdata <= '0;
    tracker       = new();
    idle_enabled  = 1'b1;
    stall_request = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: countdown, long press and long release, release during
    // debounce, short release, release while idle.
    apply_settings(1, 2, 3);
    hold_then_release(4'd0, 7);
    hold_then_release(4'd15, 1);
    hold_then_release(4'd7, 3);
    send_sample(4'd3, 1'b0);
    in_valid <= 1'b0;
    // Zero stable time confirms on the second sample; long detection is off.
    apply_settings(1, 0, 0);
    hold_then_release(4'd2, 5);
    in_valid <= 1'b0;

    run_phase(65535, 65535, 65535, 90, 1'b1, 1'b0);
    run_phase(1, 0, 0, 90, 1'b1, 1'b0);
    run_phase(65535, 0, 1, 60, 1'b0, 1'b0);
    for (k = 0; k < 3; k++) begin
      scan = $urandom_range(1, 300);
      run_phase(scan, scan * $urandom_range(0, 4) + $urandom_range(0, scan - 1),
                ($urandom_range(0, 3) == 0) ? 0 :
                  scan * $urandom_range(1, 8) + $urandom_range(0, scan - 1),
                90, 1'b1, k == 1);
    end
    run_phase(10, 50, 1000, 100, 1'b1, 1'b0);

    idle_enabled = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    $display("Ran %0d scan samples over nine register settings with random stalls.",
             tracker.samples_taken);
    $display("Events checked: %0d press, %0d long start, %0d long release, %0d short release.",
             tracker.events_by_code[EV_PRESS], tracker.events_by_code[EV_LONG_START],
             tracker.events_by_code[EV_LONG_RELEASE],
             tracker.events_by_code[EV_SHORT_RELEASE]);
    if (tracker.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
